// ===== design/ugi_pkg.sv =====
// Shared types, codes and fixed-point helpers of the uniform grid interpolator.
package ugi_pkg;

  localparam int FBITS = 30;

  typedef logic signed [32:0] q33_t;
  typedef logic signed [33:0] q34_t;

  localparam q33_t ONE_Q33 = 33'sd1073741824;
  localparam q34_t ONE_Q34 = 34'sd1073741824;

  localparam logic [1:0] CFG_GRID_START      = 2'd0;
  localparam logic [1:0] CFG_INVERSE_SPACING = 2'd1;
  localparam logic [1:0] CFG_TABLE_SIZE      = 2'd2;
  localparam logic [1:0] CFG_INTERP_MODE     = 2'd3;

  localparam logic [1:0] MODE_NEAREST = 2'd0;
  localparam logic [1:0] MODE_LINEAR  = 2'd1;
  localparam logic [1:0] MODE_CUBIC   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SMALL = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  // Which weight formula a query uses.
  typedef enum logic [2:0] {
    FORM_ZERO,
    FORM_NEAR0,
    FORM_NEAR1,
    FORM_LIN,
    FORM_LEFT,
    FORM_RIGHT,
    FORM_CUBIC
  } form_t;

  typedef struct packed {
    form_t       form;
    logic [29:0] frac;
  } wg_in_t;

  // floor(x*y / 2^30)
  function automatic q34_t qm(q33_t x, q33_t y);
    logic signed [65:0] p;
    p = x * y;
    return p[63:30];
  endfunction

endpackage

// ===== design/ugi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ugi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== design/ugi_weight_gen.sv =====
// Three-stage pipeline that forms the four interpolation weights from the fraction.
module ugi_weight_gen (
  input  logic            clk,
  input  logic            en,
  input  ugi_pkg::wg_in_t wg_in,
  output ugi_pkg::q34_t   weight [4]
);
  typedef enum logic [1:0] {DIV_ZERO, DIV_ONE, DIV_TWO, DIV_SIX} div_t;

  // Signed division truncating toward zero; by six it is a halving and an exact
  // reciprocal multiply by three.
  function automatic ugi_pkg::q34_t div_trunc(ugi_pkg::q34_t n, div_t dv);
    logic        neg;
    logic [33:0] mag;
    logic [63:0] prod;
    logic [33:0] q;
    neg  = n[33];
    mag  = neg ? 34'(-n) : 34'(n);
    prod = 64'(mag[32:1]) * 64'(32'hAAAAAAAB);
    case (dv)
      DIV_ONE: q = mag;
      DIV_TWO: q = mag >> 1;
      DIV_SIX: q = 34'(prod[63:33]);
      default: q = '0;
    endcase
    return neg ? ugi_pkg::q34_t'(-q) : ugi_pkg::q34_t'(q);
  endfunction

  // Stage A: first-level products.
  ugi_pkg::q33_t a0, b0, c0, e0;
  ugi_pkg::q34_t t_ab, t_bc, t_ac, t_eb, t_ea;

  always_comb begin
    a0 = ugi_pkg::q33_t'({3'b000, wg_in.frac});
    b0 = a0 - ugi_pkg::ONE_Q33;
    c0 = a0 - (ugi_pkg::ONE_Q33 <<< 1);
    e0 = a0 + ugi_pkg::ONE_Q33;
    t_ab = ugi_pkg::qm(a0, b0);
    t_bc = ugi_pkg::qm(b0, c0);
    t_ac = ugi_pkg::qm(a0, c0);
    t_eb = ugi_pkg::qm(e0, b0);
    t_ea = ugi_pkg::qm(e0, a0);
  end

  ugi_pkg::form_t form_a;
  logic [29:0]    frac_a;
  ugi_pkg::q33_t  p_ab, p_bc, p_ac, p_eb, p_ea;

  always_ff @(posedge clk) begin
    if (en) begin
      form_a <= wg_in.form;
      frac_a <= wg_in.frac;
      p_ab   <= t_ab[32:0];
      p_bc   <= t_bc[32:0];
      p_ac   <= t_ac[32:0];
      p_eb   <= t_eb[32:0];
      p_ea   <= t_ea[32:0];
    end
  end

  // Stage B: second-level products and per-lane numerator and divisor.
  ugi_pkg::q33_t a1, b1, c1;
  ugi_pkg::q34_t q_abc, q_ebc, q_eac, q_eab;
  ugi_pkg::q34_t num_next [4];
  div_t          dv_next [4];

  always_comb begin
    a1 = ugi_pkg::q33_t'({3'b000, frac_a});
    b1 = a1 - ugi_pkg::ONE_Q33;
    c1 = a1 - (ugi_pkg::ONE_Q33 <<< 1);
    q_abc = ugi_pkg::qm(p_ab, c1);
    q_ebc = ugi_pkg::qm(p_eb, c1);
    q_eac = ugi_pkg::qm(p_ea, c1);
    q_eab = ugi_pkg::qm(p_ea, b1);
    for (int k = 0; k < 4; k++) begin
      num_next[k] = '0;
      dv_next[k]  = DIV_ZERO;
    end
    case (form_a)
      ugi_pkg::FORM_NEAR0: begin
        num_next[0] = ugi_pkg::ONE_Q34; dv_next[0] = DIV_ONE;
      end
      ugi_pkg::FORM_NEAR1: begin
        num_next[1] = ugi_pkg::ONE_Q34; dv_next[1] = DIV_ONE;
      end
      ugi_pkg::FORM_LIN: begin
        num_next[0] = ugi_pkg::ONE_Q34 - 34'(a1); dv_next[0] = DIV_ONE;
        num_next[1] = 34'(a1);                    dv_next[1] = DIV_ONE;
      end
      ugi_pkg::FORM_LEFT: begin
        num_next[0] = 34'(p_bc);  dv_next[0] = DIV_TWO;
        num_next[1] = -34'(p_ac); dv_next[1] = DIV_ONE;
        num_next[2] = 34'(p_ab);  dv_next[2] = DIV_TWO;
      end
      ugi_pkg::FORM_RIGHT: begin
        num_next[0] = 34'(p_ab);  dv_next[0] = DIV_TWO;
        num_next[1] = -34'(p_eb); dv_next[1] = DIV_ONE;
        num_next[2] = 34'(p_ea);  dv_next[2] = DIV_TWO;
      end
      ugi_pkg::FORM_CUBIC: begin
        num_next[0] = -q_abc; dv_next[0] = DIV_SIX;
        num_next[1] = q_ebc;  dv_next[1] = DIV_TWO;
        num_next[2] = -q_eac; dv_next[2] = DIV_TWO;
        num_next[3] = q_eab;  dv_next[3] = DIV_SIX;
      end
      default: ;
    endcase
  end

  ugi_pkg::q34_t num_b [4];
  div_t          dv_b [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        num_b[k] <= num_next[k];
        dv_b[k]  <= dv_next[k];
      end
    end
  end

  // Stage C: the divisions.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        weight[k] <= div_trunc(num_b[k], dv_b[k]);
      end
    end
  end
endmodule

// ===== design/uniform_grid_interpolator.sv =====
// Top level of the uniform grid interpolator: table storage, position decode and datapath.
//
// The block keeps a table of samples on an equally spaced grid and answers queries with a
// nearest, linear or four-point cubic interpolation in Q16.16. Items enter through a
// valid/ready channel: a write item stores one sample and gives no result, a query item
// gives exactly one result transfer with the value and a status code. The pipeline takes
// one item in every clock cycle while the pipeline is not held and has eight register
// stages; the path runs through the position subtract, the 32x32 scaling multiplier, the
// table read, three stages of weight products and divisions, the sample-times-weight
// multipliers and the final round and saturate stage. The whole pipeline holds when the
// result register is full and not taken, so a stall loses nothing. The table is split into
// four banks by the low two index bits so that the four neighboring samples of a cubic
// query are read in the same cycle; writes go to the banks at the same pipeline stage as
// query reads, so a query always sees every write accepted before it. The table has no
// reset and needs no clearing pass; an entry must be written before a query uses it.
// Configuration registers may only be written while no item is in flight.
module uniform_grid_interpolator #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic               kind,
  input  logic [7:0]         entry_index,
  input  logic signed [31:0] entry_value,
  input  logic signed [31:0] query_x,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [31:0] y_value,
  output logic [1:0]         status,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  localparam int IDX_W      = $clog2(TABLE_DEPTH);
  localparam int EW         = IDX_W + 1;
  localparam int SZ_W       = $clog2(TABLE_DEPTH + 1);
  localparam int BANK_DEPTH = (TABLE_DEPTH + 3) / 4;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  // Configuration registers.
  logic signed [31:0] grid_start;
  logic [31:0]        inverse_spacing;
  logic [8:0]         table_size;
  logic [1:0]         interp_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_start      <= '0;
      inverse_spacing <= 32'd65536;
      table_size      <= 9'd2;
      interp_mode     <= ugi_pkg::MODE_LINEAR;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ugi_pkg::CFG_GRID_START:      grid_start      <= cfg_data;
        ugi_pkg::CFG_INVERSE_SPACING: inverse_spacing <= cfg_data;
        ugi_pkg::CFG_TABLE_SIZE:      table_size      <= cfg_data[8:0];
        ugi_pkg::CFG_INTERP_MODE:     interp_mode     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves whenever the result register can take a new value.
  logic adv;
  assign adv        = !result_valid || result_ready;
  assign item_ready = adv;

  // Stage 1: offset from the grid start, exact in 33 bits.
  logic               v1, kind1;
  logic [7:0]         eidx1;
  logic [31:0]        eval1;
  logic signed [32:0] d1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind1 <= kind;
      eidx1 <= entry_index;
      eval1 <= entry_value;
      d1    <= 33'(query_x) - 33'(grid_start);
    end
  end

  // Stage 2: scale by the inverse spacing into an index and a 32-bit fraction.
  logic        v2, kind2, dzero2, dneg2;
  logic [7:0]  eidx2;
  logic [31:0] eval2;
  logic [63:0] prod2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind2  <= kind1;
      eidx2  <= eidx1;
      eval2  <= eval1;
      dzero2 <= (d1 == '0);
      dneg2  <= d1[32];
      prod2  <= 64'(d1[31:0]) * 64'(inverse_spacing);
    end
  end

  // Stage 3: range check, formula choice, table write or table read.
  logic [SZ_W-1:0]  size_eff;
  logic [31:0]      idx_hi;
  logic [IDX_W-1:0] i2, size_m2, size_m3;
  logic             oor2;
  ugi_pkg::form_t   form_next;
  logic [1:0]       status_next;
  logic [IDX_W-1:0] base_next;
  logic [3:0]       used_next;

  always_comb begin
    size_eff = (32'(table_size) > 32'(TABLE_DEPTH)) ? SZ_W'(TABLE_DEPTH) : SZ_W'(table_size);
    idx_hi   = prod2[63:32];
    i2       = idx_hi[IDX_W-1:0];
    size_m2  = IDX_W'(32'(size_eff) - 32'd2);
    size_m3  = IDX_W'(32'(size_eff) - 32'd3);
    oor2     = (32'(size_eff) < 32'd2) || (idx_hi > 32'(size_eff) - 32'd2);

    form_next   = ugi_pkg::FORM_ZERO;
    status_next = ugi_pkg::ST_OK;
    base_next   = i2;
    if (dzero2) begin
      // A query exactly at the grid start returns the first sample in every mode.
      form_next = ugi_pkg::FORM_NEAR0;
      base_next = '0;
    end else if (dneg2 || oor2) begin
      status_next = ugi_pkg::ST_RANGE;
    end else begin
      unique case (interp_mode)
        ugi_pkg::MODE_NEAREST: begin
          form_next = (prod2[31:0] > 32'h8000_0000) ? ugi_pkg::FORM_NEAR1
                                                    : ugi_pkg::FORM_NEAR0;
        end
        ugi_pkg::MODE_CUBIC: begin
          if (32'(size_eff) < 32'd3) begin
            status_next = ugi_pkg::ST_SMALL;
          end else if (i2 == '0) begin
            form_next = ugi_pkg::FORM_LEFT;
          end else if (i2 == size_m2) begin
            form_next = ugi_pkg::FORM_RIGHT;
            base_next = size_m3;
          end else begin
            form_next = ugi_pkg::FORM_CUBIC;
            base_next = i2 - IDX_W'(1);
          end
        end
        default: form_next = ugi_pkg::FORM_LIN;
      endcase
    end

    case (form_next)
      ugi_pkg::FORM_NEAR0: used_next = 4'b0001;
      ugi_pkg::FORM_NEAR1: used_next = 4'b0010;
      ugi_pkg::FORM_LIN:   used_next = 4'b0011;
      ugi_pkg::FORM_LEFT,
      ugi_pkg::FORM_RIGHT: used_next = 4'b0111;
      ugi_pkg::FORM_CUBIC: used_next = 4'b1111;
      default:             used_next = 4'b0000;
    endcase
  end

  // Four banks; bank j holds the entries whose index is j modulo four.
  logic [BANK_AW-1:0] rd_addr [4];
  logic [31:0]        rd_data [4];
  logic               wr_en [4];
  logic [BANK_AW-1:0] wr_addr;
  logic               wr_ok;

  assign wr_ok   = adv && v2 && !kind2 && (32'(eidx2) < 32'(TABLE_DEPTH));
  assign wr_addr = BANK_AW'(eidx2 >> 2);

  always_comb begin
    logic [1:0]    off;
    logic [EW-1:0] ent;
    for (int j = 0; j < 4; j++) begin
      off        = 2'(2'(j) - base_next[1:0]);
      ent        = EW'(base_next) + EW'(off);
      rd_addr[j] = BANK_AW'(ent >> 2);
      wr_en[j]   = wr_ok && (eidx2[1:0] == 2'(j));
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_bank
    ugi_ram #(
      .WIDTH(32),
      .DEPTH(BANK_DEPTH)
    ) u_bank (
      .clk  (clk),
      .we   (wr_en[j]),
      .waddr(wr_addr),
      .wdata(eval2),
      .re   (adv),
      .raddr(rd_addr[j]),
      .rdata(rd_data[j])
    );
  end

  logic            v3;
  logic [1:0]      rot3, status3;
  logic [3:0]      used3;
  ugi_pkg::wg_in_t wg3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2 && kind2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rot3      <= base_next[1:0];
      status3   <= status_next;
      used3     <= used_next;
      wg3.form  <= form_next;
      wg3.frac  <= prod2[31:2];
    end
  end

  // Stages 4 to 6: weights are formed while the samples wait alongside.
  ugi_pkg::q34_t weight6 [4];

  ugi_weight_gen u_weight_gen (
    .clk   (clk),
    .en    (adv),
    .wg_in (wg3),
    .weight(weight6)
  );

  logic               v4, v5, v6;
  logic [1:0]         st4, st5, st6;
  logic signed [31:0] s4 [4];
  logic signed [31:0] s5 [4];
  logic signed [31:0] s6 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st4 <= status3;
      st5 <= st4;
      st6 <= st5;
      for (int k = 0; k < 4; k++) begin
        // Lanes without a weight read as zero so that no unused entry reaches the sum.
        s4[k] <= used3[k] ? rd_data[2'(rot3 + 2'(k))] : 32'sd0;
        s5[k] <= s4[k];
        s6[k] <= s5[k];
      end
    end
  end

  // Stage 7: sample times weight.
  logic               v7;
  logic [1:0]         st7;
  logic signed [65:0] prod7 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st7 <= st6;
      for (int k = 0; k < 4; k++) begin
        prod7[k] <= s6[k] * weight6[k];
      end
    end
  end

  // Stage 8: sum, round half up, saturate.
  logic signed [67:0] sum8, yq8;
  logic               sat_hi, sat_lo;

  always_comb begin
    sum8   = 68'(prod7[0]) + 68'(prod7[1]) + 68'(prod7[2]) + 68'(prod7[3]);
    yq8    = (sum8 + 68'sd536870912) >>> ugi_pkg::FBITS;
    sat_hi = yq8 > 68'sd2147483647;
    sat_lo = yq8 < -68'sd2147483648;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (sat_hi) begin
        y_value <= 32'sh7FFF_FFFF;
        status  <= ugi_pkg::ST_SAT;
      end else if (sat_lo) begin
        y_value <= 32'sh8000_0000;
        status  <= ugi_pkg::ST_SAT;
      end else begin
        y_value <= yq8[31:0];
        status  <= st7;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // Out of range and too-small results carry a zero value.
  a_flagged_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == ugi_pkg::ST_RANGE || status == ugi_pkg::ST_SMALL)
      |-> y_value == 32'sd0)
    else $error("flagged result with nonzero value");

  // A saturated result sits at one of the two limits.
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ugi_pkg::ST_SAT
      |-> (y_value == 32'sh7FFF_FFFF || y_value == 32'sh8000_0000))
    else $error("saturated result not at a limit");

  // A write item never turns into a result slot.
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    adv && v2 && !kind2 |=> !v3)
    else $error("write item entered the result path");
`endif
endmodule

// ===== tb/sv/ugi_checker.sv =====
// Scoreboard of the uniform grid interpolator: predicts every query result and compares it.
`timescale 1ns / 1ps

module ugi_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_ready,
  input  logic               kind,
  input  logic [7:0]         entry_index,
  input  logic signed [31:0] entry_value,
  input  logic signed [31:0] query_x,
  input  logic               result_valid,
  input  logic               result_ready,
  input  logic signed [31:0] y_value,
  input  logic [1:0]         status,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 errors
);

  typedef logic signed [79:0] wide_t;
  typedef struct packed {
    logic signed [31:0] y;
    logic [1:0]         st;
  } answer_t;

  localparam wide_t ONE  = 80'sd1073741824;
  localparam wide_t HALF = 80'sd536870912;
  localparam wide_t YMAX = 80'sd2147483647;
  localparam wide_t YMIN = -80'sd2147483648;

  logic signed [31:0] samples [256];
  logic signed [31:0] start_x;
  logic [31:0]        inv_step;
  logic [8:0]         tbl_size;
  logic [1:0]         mode;
  answer_t            answers [$];

  function automatic wide_t fx_mul(wide_t x, wide_t y);
    return (x * y) >>> 30;
  endfunction

  function automatic answer_t interpolate(logic signed [31:0] qx);
    answer_t r;
    wide_t d, a, b, c, e, sum, y;
    wide_t w [4];
    logic [63:0] prod;
    logic [31:0] idx, frac;
    int sz, base, np;
    bit calc;
    r = '0;
    sz = (tbl_size > 256) ? 256 : int'(tbl_size);
    d = wide_t'(qx) - wide_t'(start_x);
    if (d == 0) begin
      r.y = samples[0];
    end else if (d < 0) begin
      r.st = ugi_pkg::ST_RANGE;
    end else begin
      prod = d[63:0] * {32'd0, inv_step};
      idx = prod[63:32];
      frac = prod[31:0];
      if (sz < 2 || longint'(idx) > longint'(sz - 2)) begin
        r.st = ugi_pkg::ST_RANGE;
      end else begin
        a = '0;
        a[29:0] = frac[31:2];
        b = a - ONE;
        c = a - 2 * ONE;
        e = a + ONE;
        w[0] = ONE - a;
        w[1] = a;
        w[2] = 0;
        w[3] = 0;
        base = int'(idx);
        np = 2;
        calc = 1;
        if (mode == ugi_pkg::MODE_NEAREST) begin
          // A tie at exactly one half stays on the lower sample.
          r.y = (frac > 32'h8000_0000) ? samples[idx + 1] : samples[idx];
          calc = 0;
        end else if (mode == ugi_pkg::MODE_CUBIC) begin
          if (sz < 3) begin
            r.st = ugi_pkg::ST_SMALL;
            calc = 0;
          end else if (idx == 0) begin
            base = 0;
            np = 3;
            w[0] = fx_mul(b, c) / 2;
            w[1] = -fx_mul(a, c);
            w[2] = fx_mul(a, b) / 2;
          end else if (int'(idx) == sz - 2) begin
            base = sz - 3;
            np = 3;
            w[0] = fx_mul(a, b) / 2;
            w[1] = -fx_mul(e, b);
            w[2] = fx_mul(e, a) / 2;
          end else begin
            base = int'(idx) - 1;
            np = 4;
            w[0] = -fx_mul(fx_mul(a, b), c) / 6;
            w[1] = fx_mul(fx_mul(e, b), c) / 2;
            w[2] = -fx_mul(fx_mul(e, a), c) / 2;
            w[3] = fx_mul(fx_mul(e, a), b) / 6;
          end
        end
        if (calc) begin
          sum = 0;
          for (int k = 0; k < np; k++) sum += wide_t'(samples[base + k]) * w[k];
          y = (sum + HALF) >>> 30;
          if (y > YMAX) begin
            y = YMAX;
            r.st = ugi_pkg::ST_SAT;
          end else if (y < YMIN) begin
            y = YMIN;
            r.st = ugi_pkg::ST_SAT;
          end
          r.y = y[31:0];
        end
      end
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s differs: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      start_x <= '0;
      inv_step <= 32'd65536;
      tbl_size <= 9'd2;
      mode <= ugi_pkg::MODE_LINEAR;
      answers.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          ugi_pkg::CFG_GRID_START:      start_x <= cfg_data;
          ugi_pkg::CFG_INVERSE_SPACING: inv_step <= cfg_data;
          ugi_pkg::CFG_TABLE_SIZE:      tbl_size <= cfg_data[8:0];
          default:                      mode <= cfg_data[1:0];
        endcase
      end
      if (result_valid && result_ready) begin
        if (answers.size() == 0) begin
          report("unexpected result transfer", y_value, 'x);
        end else begin
          want = answers.pop_front();
          if (y_value !== want.y) report("y_value", y_value, want.y);
          if (status !== want.st) report("status", status, want.st);
        end
      end
      if (item_valid && item_ready) begin
        if (kind == 1'b0) samples[entry_index] = entry_value;
        else answers.push_back(interpolate(query_x));
      end
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top of the uniform grid interpolator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

  // Longest quiet stretch: a drain of the 8-stage pipeline plus the longest stalls.
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE = 12;

  logic               clk, rst;
  logic               item_valid, item_ready, kind;
  logic [7:0]         entry_index;
  logic signed [31:0] entry_value, query_x;
  logic               result_valid, result_ready;
  logic signed [31:0] y_value;
  logic [1:0]         status;
  logic               cfg_write;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;
  int                 errors;

  // Counts of query transfers sent and result transfers taken, for draining.
  int  queries_sent, results_taken, quiet;
  bit  calm;
  // Geometry of the current setting, used to aim queries inside the grid.
  longint span_start, span_step;
  int     span_size;

  uniform_grid_interpolator DUT (.*);
  ugi_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (result_valid && result_ready) results_taken++;
    if ((item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet = 0;
    end else if (++quiet >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // The receiver stalls in random bursts until the calm final phase.
  initial begin
    int hold;
    hold = 0;
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        result_ready <= 1'b0;
        hold = $urandom_range(1, 16) - 1;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // One transfer on the item channel. Valid is left high on return, so the caller either
  // starts the next transfer in the same step or lowers valid.
  task automatic push(bit k, logic [7:0] idx, logic [31:0] val, logic [31:0] x, bit gap);
    if (gap && !calm && $urandom_range(0, 7) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    item_valid <= 1'b1;
    kind <= k;
    entry_index <= idx;
    entry_value <= val;
    query_x <= x;
    forever begin
      @(posedge clk);
      if (item_ready) break;
    end
    if (k) queries_sent++;
  endtask

  task automatic put_entry(logic [7:0] idx, logic [31:0] val);
    push(1'b0, idx, val, $urandom, 1'b1);
  endtask

  task automatic ask(logic [31:0] x);
    push(1'b1, 8'($urandom), $urandom, x, 1'b1);
  endtask

  // Waits until every result is in, then lets writes that give no result leave the pipe.
  task automatic drain();
    item_valid <= 1'b0;
    while (queries_sent != results_taken) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Registers are written only with the pipeline empty.
  task automatic set_reg(logic [1:0] idx, logic [31:0] val);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Picks a random setting; spacing is chosen first so that queries can be aimed.
  task automatic new_setting();
    logic [31:0] sx, inv;
    longint s;
    int sz;
    case ($urandom_range(0, 4))
      0: sx = 32'h8000_0000;
      1: sx = 32'h7FFF_FFFF;
      2: sx = 32'd0;
      default: sx = $urandom;
    endcase
    s = $urandom_range(1, 32'h0008_0000);
    inv = (s == 1) ? 32'hFFFF_FFFF : 32'((64'h1_0000_0000) / s);
    case ($urandom_range(0, 9))
      0: inv = 32'd1;
      1: inv = 32'hFFFF_FFFF;
      default: ;
    endcase
    case ($urandom_range(0, 6))
      0: sz = 2;
      1: sz = 3;
      2: sz = 4;
      3: sz = 256;
      4: sz = $urandom_range(257, 511);
      default: sz = $urandom_range(2, 256);
    endcase
    span_start = longint'(signed'(sx));
    span_step = s;
    span_size = (sz > 256) ? 256 : sz;
    set_reg(ugi_pkg::CFG_GRID_START, sx);
    set_reg(ugi_pkg::CFG_INVERSE_SPACING, inv);
    set_reg(ugi_pkg::CFG_TABLE_SIZE, 32'(sz));
    set_reg(ugi_pkg::CFG_INTERP_MODE, $urandom_range(0, 3));
  endtask

  function automatic logic [31:0] aimed_x();
    longint x;
    case ($urandom_range(0, 9))
      0: x = span_start + $urandom_range(0, 4) - 2;
      1: x = longint'(signed'(32'($urandom)));
      default: x = span_start + longint'($urandom_range(0, 32'((span_size - 1) * span_step)));
    endcase
    if (x > 64'sd2147483647 || x < -64'sd2147483648) x = longint'(signed'(32'($urandom)));
    return x[31:0];
  endfunction

  function automatic logic [31:0] any_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    rst <= 1'b1;
    item_valid <= 1'b0;
    kind <= 1'b0;
    entry_index <= '0;
    entry_value <= '0;
    query_x <= '0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    calm = 0;
    quiet = 0;
    queries_sent = 0;
    results_taken = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Fill the whole table first so that no query can ever touch an unwritten entry.
    for (int k = 0; k < 256; k++) put_entry(k[7:0], any_value());

    // Directed part, first with the reset setting: size 2, linear, unit spacing.
    ask(32'h0000_0000);   // exactly at the grid start
    ask(32'hFFFF_FFFF);   // just left of the grid
    ask(32'h0000_8000);   // halfway through the only interval
    ask(32'h0001_0000);   // one past the last usable interval
    ask(32'h7FFF_FFFF);
    ask(32'h8000_0000);
    // Cubic on a two entry table is too small, except at the start itself.
    set_reg(ugi_pkg::CFG_INTERP_MODE, ugi_pkg::MODE_CUBIC);
    ask(32'h0000_8000);
    ask(32'h0000_0000);
    // A size below two puts every other position out of range.
    set_reg(ugi_pkg::CFG_TABLE_SIZE, 32'd0);
    ask(32'h0000_0001);
    // Cubic on eight entries with saturating samples at the left end.
    set_reg(ugi_pkg::CFG_TABLE_SIZE, 32'd8);
    put_entry(8'd0, 32'h7FFF_FFFF);
    put_entry(8'd1, 32'h8000_0000);
    put_entry(8'd2, 32'h7FFF_FFFF);
    ask(32'h0000_8000);   // left end formula
    ask(32'h0003_4000);   // four point interior
    ask(32'h0006_C000);   // right end formula
    // Nearest: a tie keeps the lower sample, just above it takes the upper one.
    set_reg(ugi_pkg::CFG_INTERP_MODE, ugi_pkg::MODE_NEAREST);
    ask(32'h0000_8000);
    ask(32'h0000_8001);
    // The unused mode behaves as linear; sizes beyond the depth act as the depth.
    set_reg(ugi_pkg::CFG_INTERP_MODE, 32'd3);
    set_reg(ugi_pkg::CFG_TABLE_SIZE, 32'd511);
    ask(32'h00FE_FFFF);
    // A zero inverse spacing maps every position at or right of the start onto the start.
    set_reg(ugi_pkg::CFG_INVERSE_SPACING, 32'd0);
    ask(32'h1234_5678);
    set_reg(ugi_pkg::CFG_INVERSE_SPACING, 32'hFFFF_FFFF);
    set_reg(ugi_pkg::CFG_GRID_START, 32'h8000_0000);
    ask(32'h8000_0001);

    // Random part: mostly aimed queries, some table updates, over several settings.
    for (int phase = 0; phase < 6; phase++) begin
      calm = (phase == 5);
      new_setting();
      for (int n = 0; n < 45; n++) begin
        if (n == 22) drain();   // let the pipeline run dry once per setting
        if ($urandom_range(0, 9) < 3) put_entry(8'($urandom), any_value());
        else ask(aimed_x());
      end
    end

    drain();
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
